### sv/epdste_pkg.sv
// ----------------------------------------------------------------------------
// epdste_pkg
// Shared constants, codes and types of the e-paper shadow transition encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package epdste_pkg;

  localparam int PANEL_WIDTH   = 400;
  localparam int PANEL_HEIGHT  = 300;
  localparam int SHADOW_STRIDE = PANEL_WIDTH / 8;
  localparam int SHADOW_DEPTH  = SHADOW_STRIDE * PANEL_HEIGHT;
  localparam int ADDR_W        = $clog2(SHADOW_DEPTH);

  // item function codes
  localparam logic [1:0] FUNC_FULL    = 2'd0;
  localparam logic [1:0] FUNC_PARTIAL = 2'd1;
  localparam logic [1:0] FUNC_INVAL   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_VALID = 2'd1;
  localparam logic [1:0] ST_OUTSIDE   = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIN_X      = 2'd0;
  localparam logic [1:0] REG_WIN_Y      = 2'd1;
  localparam logic [1:0] REG_WIN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_WIN_HEIGHT = 2'd3;

  // horizontal extent of the partial rectangle, [win_x, x_end)
  typedef struct packed {
    logic [8:0] win_x;
    logic [9:0] x_end;
  } win_bounds_t;

  // per-group control from the pipeline to the lane group
  typedef struct packed {
    logic full;   // full-frame byte: code is (0, new), shadow takes new bits
    logic emit;   // codes are produced; otherwise both code bytes are zero
  } grp_ctrl_t;

endpackage

`default_nettype wire

### sv/epdste_if.sv
// ----------------------------------------------------------------------------
// epdste item / result channels
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface epdste_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [8:0] row;
  logic [5:0] byte_col;
  logic [7:0] pixels;

  modport source (output valid, func, row, byte_col, pixels, input ready);
  modport sink   (input valid, func, row, byte_col, pixels, output ready);
endinterface

interface epdste_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_first;
  logic [7:0] code_second;
  logic [1:0] status;

  modport source (output valid, code_first, code_second, status, input ready);
  modport sink   (input valid, code_first, code_second, status, output ready);
endinterface

`default_nettype wire

### sv/epdste_lane.sv
// ----------------------------------------------------------------------------
// epdste_lane
// One pixel: window test, merged bit and 2-bit transition code.
// ----------------------------------------------------------------------------
`default_nettype none

module epdste_lane
  import epdste_pkg::*;
(
  input  wire logic [8:0]  x,
  input  wire win_bounds_t win,
  input  wire logic        full,
  input  wire logic        old_bit,
  input  wire logic        pix_bit,
  output logic       [1:0] code,
  output logic             new_bit
);

  logic in_win;

  assign in_win  = full || (x >= win.win_x && {1'b0, x} < win.x_end);
  assign new_bit = in_win ? pix_bit : old_bit;
  assign code    = {old_bit, new_bit};

endmodule

`default_nettype wire

### sv/epdste_group.sv
// ----------------------------------------------------------------------------
// epdste_group
// Eight pixel lanes side by side plus the merge that packs their codes and
// rebuilds the shadow byte.
// ----------------------------------------------------------------------------
`default_nettype none

module epdste_group
  import epdste_pkg::*;
(
  input  wire logic [5:0]  byte_col,
  input  wire logic [7:0]  pixels,
  input  wire logic [7:0]  old_byte,
  input  wire win_bounds_t win,
  input  wire grp_ctrl_t   ctrl,
  output logic      [7:0]  code_first,
  output logic      [7:0]  code_second,
  output logic      [7:0]  new_byte
);

  logic [1:0] code [8];
  logic [7:0] new_bits;

  for (genvar i = 0; i < 8; i++) begin : g_lane
    epdste_lane u_lane (
      .x       ({byte_col, 3'(i)}),
      .win     (win),
      .full    (ctrl.full),
      .old_bit (old_byte[7-i]),
      .pix_bit (pixels[7-i]),
      .code    (code[i]),
      .new_bit (new_bits[7-i])
    );
  end

  assign new_byte = new_bits;

  always_comb begin
    if (ctrl.emit) begin
      code_first  = {code[0], code[1], code[2], code[3]};
      code_second = {code[4], code[5], code[6], code[7]};
    end else begin
      code_first  = '0;
      code_second = '0;
    end
  end

endmodule

`default_nettype wire

### sv/epd_shadow_transition_encoder.sv
// ----------------------------------------------------------------------------
// epd_shadow_transition_encoder
// 1bpp frame shadow with full-frame and partial-window transition encoding.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the result side stalls, and returns one
// result per transaction via the stage 1 and result registers. The shadow lives in
// a single-port-write, registered-read RAM; each item reads its byte at
// acceptance and the merged byte is written back as the item leaves stage 1, with a
// bypass so back-to-back items on the same byte see the newest data. After
// reset a clearing pass fills the shadow with white, one byte per cycle, over
// all 15000 bytes (PANEL_WIDTH/8 * PANEL_HEIGHT); item ready stays low until it
// finishes, while register writes are taken throughout.
`default_nettype none

module epd_shadow_transition_encoder
  import epdste_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  epdste_item_if.sink      item,
  epdste_result_if.source  result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic [10:0] PW11     = 11'(PANEL_WIDTH);
  localparam logic [10:0] PH11     = 11'(PANEL_HEIGHT);
  localparam logic [10:0] STRIDE11 = 11'(SHADOW_STRIDE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SHADOW_DEPTH - 1);

  // ---------------- configuration ----------------
  logic [8:0] win_x, win_y, win_width, win_height;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x      <= '0;
      win_y      <= '0;
      win_width  <= 9'd400;
      win_height <= 9'd300;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIN_X:      win_x      <= pwdata[8:0];
        REG_WIN_Y:      win_y      <= pwdata[8:0];
        REG_WIN_WIDTH:  win_width  <= pwdata[8:0];
        REG_WIN_HEIGHT: win_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIN_X:      prdata = {23'd0, win_x};
      REG_WIN_Y:      prdata = {23'd0, win_y};
      REG_WIN_WIDTH:  prdata = {23'd0, win_width};
      REG_WIN_HEIGHT: prdata = {23'd0, win_height};
      default:        prdata = '0;
    endcase
  end

  // window geometry; the user must keep it static while items are in flight, the block does not enforce it
  logic [9:0]  x_end, y_end;
  logic [10:0] ax0, ax_end_raw, ax_end;
  logic        rect_bad;

  assign x_end      = {1'b0, win_x} + {1'b0, win_width};
  assign y_end      = {1'b0, win_y} + {1'b0, win_height};
  assign ax0        = {2'b0, win_x[8:3], 3'b0};
  assign ax_end_raw = (11'(x_end) + 11'd7) & ~11'd7;
  assign ax_end     = (ax_end_raw > PW11) ? PW11 : ax_end_raw;
  assign rect_bad   = (win_width == '0) || (win_height == '0) ||
                      (11'(x_end) > PW11) || (11'(y_end) > PH11);

  // ---------------- clearing pass ----------------
  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid, s1_adv, accept;

  assign s1_adv     = s1_valid && (!result.valid || result.ready);
  assign item.ready = !clearing && (!s1_valid || s1_adv);
  assign accept     = item.valid && item.ready;

  // ---------------- stage 0: decode, address, status ----------------
  logic              frame_valid, frame_valid_next;
  logic [10:0]       row11, col11, gx11;
  logic [19:0]       addr_full;
  logic [ADDR_W-1:0] rd_addr;
  logic              off_panel, outside;
  logic [1:0]        st0;
  logic              wr0, full0, emit0;

  assign row11     = 11'(item.row);
  assign col11     = 11'(item.byte_col);
  assign gx11      = {2'b0, item.byte_col, 3'b0};
  assign addr_full = 20'(item.row) * 20'(SHADOW_STRIDE) + 20'(item.byte_col);
  assign rd_addr   = addr_full[ADDR_W-1:0];
  assign off_panel = (row11 >= PH11) || (col11 >= STRIDE11);
  assign outside   = rect_bad || (item.row < win_y) || (11'(item.row) >= 11'(y_end)) ||
                     (gx11 < ax0) || (gx11 >= ax_end) || (col11 >= STRIDE11);

  always_comb begin
    st0              = ST_OK;
    wr0              = 1'b0;
    full0            = 1'b0;
    emit0            = 1'b0;
    frame_valid_next = frame_valid;
    case (item.func)
      FUNC_FULL: begin
        if (off_panel) begin
          st0 = ST_OUTSIDE;
        end else begin
          wr0              = 1'b1;
          full0            = 1'b1;
          emit0            = 1'b1;
          frame_valid_next = (row11 == PH11 - 11'd1) && (col11 == STRIDE11 - 11'd1);
        end
      end
      FUNC_PARTIAL: begin
        if (!frame_valid) begin
          st0 = ST_NOT_VALID;
        end else if (outside) begin
          st0 = ST_OUTSIDE;
        end else begin
          wr0   = 1'b1;
          emit0 = 1'b1;
        end
      end
      FUNC_INVAL: begin
        frame_valid_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept) begin
      frame_valid <= frame_valid_next;
    end
  end

  // ---------------- stage 1: merge and write back ----------------
  logic [1:0]        s1_status;
  logic              s1_wr;
  grp_ctrl_t         s1_ctrl;
  logic [5:0]        s1_col;
  logic [7:0]        s1_pix;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        rd_q, byp_data, old_byte, new_byte;
  logic              byp_hit, s1_wr_go;
  logic [7:0]        code_first_s1, code_second_s1;
  win_bounds_t       win;

  logic [7:0]        shadow_mem [SHADOW_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st0;
      s1_wr     <= wr0;
      s1_ctrl   <= '{full: full0, emit: emit0};
      s1_col    <= item.byte_col;
      s1_pix    <= item.pixels;
      s1_addr   <= rd_addr;
      // the write leaving stage 1 on this edge is not yet visible in the RAM
      byp_hit   <= s1_wr_go && (s1_addr == rd_addr);
      byp_data  <= new_byte;
    end
  end

  assign s1_wr_go = s1_adv && s1_wr;
  assign old_byte = s1_ctrl.full ? 8'h00 : (byp_hit ? byp_data : rd_q);
  assign win      = '{win_x: win_x, x_end: x_end};

  epdste_group u_group (
    .byte_col    (s1_col),
    .pixels      (s1_pix),
    .old_byte    (old_byte),
    .win         (win),
    .ctrl        (s1_ctrl),
    .code_first  (code_first_s1),
    .code_second (code_second_s1),
    .new_byte    (new_byte)
  );

  assign mem_we  = clearing || s1_wr_go;
  assign wr_addr = clearing ? clr_cnt : s1_addr;
  assign wr_data = clearing ? 8'hFF : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= shadow_mem[rd_addr];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.code_first  <= code_first_s1;
      result.code_second <= code_second_s1;
      result.status      <= s1_status;
    end
  end

  // ---------------- assertions ----------------
  a_err_zero_codes: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |-> result.code_first == 8'h00 &&
    result.code_second == 8'h00)
    else $error("error result carries nonzero codes");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_wr_go && !s1_valid)
    else $error("shadow update during clearing pass");

  a_last_byte_sets_valid: assert property (@(posedge clk) disable iff (rst)
    accept && item.func == FUNC_FULL && row11 == PH11 - 11'd1 &&
    col11 == STRIDE11 - 11'd1 |=> frame_valid)
    else $error("last frame byte did not validate shadow");

endmodule

`default_nettype wire
